/* design/mbc_pkg.sv */
// shared constants, types and the coefficient rom of the multiband compressor
// no dependencies; every other design file but mbc_ram imports this package
package mbc_pkg;

	localparam int BLOCK_LEN  = 64;
	localparam int MAX_BANDS  = 8;
	localparam int ADDR_W     = $clog2(BLOCK_LEN);
	localparam int CNT_W      = $clog2(BLOCK_LEN + 1);
	localparam int BAND_W     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int BANDS_W    = $clog2(MAX_BANDS + 1);
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 24;
	localparam int SUM_W      = 24;
	localparam int ENERGY_W   = 48;
	localparam int ROOT_W     = ENERGY_W / 2;
	localparam int GAIN_W     = 16;
	localparam int BC_W       = 4;
	localparam int THR_W      = 15;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 15;
	localparam int MUL_W      = 25;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int FRAC_C     = 22;
	localparam int FRAC_G     = 15;

	localparam logic [BC_W-1:0]   BC_RESET   = BC_W'(4);
	localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(3277);
	localparam logic [GAIN_W:0]   GAIN_ONE   = (GAIN_W + 1)'(32768);

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint          ONE_Q30 = 64'sd1073741824;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BAND_COUNT      = CFG_IDX_W'(0),
		CFG_LEVEL_THRESHOLD = CFG_IDX_W'(1)
	} cfg_reg_t;

	// coefficient rom: [band count - 1][band][b0, a1, a2]
	typedef logic [MAX_BANDS-1:0][MAX_BANDS-1:0][2:0][COEF_W-1:0] coef_rom_t;

	// unsigned long division by shift and subtract, elaboration only
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q, rem;
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem = rem - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// division rounded to nearest, half away from zero, positive divisor
	function automatic longint div_near(longint num, longint den);
		longint half;
		half = den >>> 1;
		if (num >= 0) return longint'(udiv64(num + half, den));
		return -longint'(udiv64(-num + half, den));
	endfunction

	// integer sine series and normalization, worked out at elaboration
	function automatic coef_rom_t build_rom();
		coef_rom_t rom;
		longint b, k, j, idx, nn, dd, r, alpha, a0, c, num, q, sn, lim;
		longint unsigned x, x2, term;
		bit neg;
		int t;
		rom = '0;
		alpha = 0;
		c = 0;
		lim = (64'sd1 <<< (COEF_W - 1)) - 1;
		for (b = 1; b <= MAX_BANDS; b++) begin
			for (k = 0; k < b; k++) begin
				for (j = 0; j < 2; j++) begin
					if (j == 0) begin
						nn = 1;
						dd = b;
					end else begin
						nn = b - 2 * (2 * k + 1);
						dd = 2 * b;
					end
					// truncated remainder of nn over a full turn
					if (nn >= 0) r = nn - 2 * dd * longint'(udiv64(nn, 2 * dd));
					else r = nn + 2 * dd * longint'(udiv64(-nn, 2 * dd));
					if (r < 0) r = r + 2 * dd;
					neg = 1'b0;
					if (r >= dd) begin
						neg = 1'b1;
						r = r - dd;
					end
					if (2 * r > dd) r = dd - r;
					x = udiv64(PI_Q30 * longint'(r) + longint'(dd >>> 1), longint'(dd));
					x2 = (x * x) >> 30;
					term = x;
					sn = 0;
					for (t = 0; t < 12; t++) begin
						if ((t & 1) == 1) sn = sn - longint'(term);
						else sn = sn + longint'(term);
						term = udiv64((term * x2) >> 30, longint'((2 * t + 2) * (2 * t + 3)));
					end
					if (neg) sn = -sn;
					if (j == 0) begin
						alpha = div_near(sn * 500, 707);
					end else begin
						c = sn;
					end
				end
				a0 = ONE_Q30 + alpha;
				for (idx = 0; idx < 3; idx++) begin
					if (idx == 0) num = alpha * 4194304;
					else if (idx == 1) num = -2 * c * 4194304;
					else num = (ONE_Q30 - alpha) * 4194304;
					q = div_near(num, a0);
					if (q > lim) q = lim;
					if (q < -lim - 1) q = -lim - 1;
					rom[b-1][k][idx] = q[COEF_W-1:0];
				end
			end
		end
		return rom;
	endfunction

	localparam coef_rom_t COEF_ROM = build_rom();

endpackage

/* design/mbc_if.sv */
// stream channels of the multiband compressor: sample input and result output
// depends on mbc_pkg for the field widths
interface mbc_in_if import mbc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       block_end;

	modport source (output valid, output sample_in, output block_end, input ready);
	modport sink (input valid, input sample_in, input block_end, output ready);
endinterface

interface mbc_out_if import mbc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       out_last;

	modport source (output valid, output sample_out, output out_last, input ready);
	modport sink (input valid, input sample_out, input out_last, output ready);
endinterface

/* design/mbc_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mbc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

/* design/mbc_div.sv */
// restoring divider, one quotient bit per cycle, energy and gain divisions
// depends on mbc_pkg for widths
module mbc_div import mbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ENERGY_W-1:0] num,
	input  logic [ROOT_W-1:0]   den,
	output logic                done,
	output logic [ENERGY_W-1:0] quot
);

	localparam int STEP_W = $clog2(ENERGY_W);

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [ENERGY_W-1:0] num_q;
	logic [ROOT_W-1:0]   den_q;
	logic [ROOT_W-1:0]   rem_q;
	logic [ROOT_W:0]     rem_sh;
	logic                fits;

	assign rem_sh = {rem_q, num_q[ENERGY_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ENERGY_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ENERGY_W-2:0], 1'b0};
			rem_q <= fits ? ROOT_W'(rem_sh - {1'b0, den_q}) : rem_sh[ROOT_W-1:0];
			quot  <= {quot[ENERGY_W-2:0], fits};
		end
	end

endmodule

/* design/mbc_sqrt.sv */
// digit-by-digit integer square root, one result bit per cycle
// depends on mbc_pkg for widths
module mbc_sqrt import mbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ENERGY_W-1:0] value,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);

	localparam int STEP_W = $clog2(ROOT_W);
	localparam int REM_W  = ROOT_W + 2;

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [ENERGY_W-1:0] val_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W+1:0]    rem_sh;
	logic [REM_W+1:0]    trial;
	logic                fits;

	assign rem_sh = {rem_q, val_q[ENERGY_W-1 -: 2]};
	assign trial  = {2'b00, root, 2'b01};
	assign fits   = rem_sh >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ROOT_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			root  <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[ENERGY_W-3:0], 2'b00};
			rem_q <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root  <= {root[ROOT_W-2:0], fits};
		end
	end

endmodule

/* design/block_multiband_compressor.sv */
// top level of the multiband compressor: sequencer, biquad datapath, stores
// depends on mbc_pkg, mbc_if, mbc_ram, mbc_div and mbc_sqrt

// Samples are taken one per cycle while valid is high into the input store
// until one is marked last or the 64th arrives; input ready then drops until
// every result of the block has been delivered. For each of the B bands the
// stored block is filtered twice through one shared 25x25 multiplier, each
// sample stepping through a store read, the multiplies and accumulations,
// rounding and the update. The first pass sums the energy; then come an
// energy division, a square root and, when the level is above threshold, a
// gain division; the second pass adds the gained band into the sum store.
// Each result is then read from the sum store and shown as the output beat.
// The sum store needs no clearing pass: the first band ignores what it reads.
module block_multiband_compressor import mbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mbc_in_if.sink                in_ch,
	mbc_out_if.source             out_ch
);

	typedef enum logic [19:0] {
		ST_LOAD       = 20'h00001,
		ST_BAND_START = 20'h00002,
		ST_RD         = 20'h00004,
		ST_MUL0       = 20'h00008,
		ST_MUL1       = 20'h00010,
		ST_MUL2       = 20'h00020,
		ST_MUL3       = 20'h00040,
		ST_YCALC      = 20'h00080,
		ST_MUL4       = 20'h00100,
		ST_ACCUM      = 20'h00200,
		ST_DIVE_GO    = 20'h00400,
		ST_DIVE_WAIT  = 20'h00800,
		ST_SQ_GO      = 20'h01000,
		ST_SQ_WAIT    = 20'h02000,
		ST_GAIN       = 20'h04000,
		ST_DIVG_GO    = 20'h08000,
		ST_DIVG_WAIT  = 20'h10000,
		ST_PASS_START = 20'h20000,
		ST_OUT_RD     = 20'h40000,
		ST_OUT_SHOW   = 20'h80000
	} state_t;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	state_t state_q;

	logic [BC_W-1:0]    band_count_q;
	logic [THR_W-1:0]   thr_cfg_q;
	logic [THR_W-1:0]   thr_q;
	logic [BANDS_W-1:0] bands_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [BAND_W-1:0]  band_q;
	logic               pass_q;

	logic signed [COEF_W-1:0]   b0_q, a1_q, a2_q;
	logic signed [SAMPLE_W-1:0] xh1_q, xh2_q;
	logic signed [SUM_W-1:0]    yh1_q, yh2_q, y_q;
	logic signed [PROD_W-1:0]   acc_q, prod_q;
	logic [ENERGY_W-1:0]        energy_q;
	logic [ROOT_W-1:0]          rms_q;
	logic [GAIN_W-1:0]          gain_q;

	logic signed [MUL_W-1:0]    opa, opb;
	logic signed [PROD_W-1:0]   y_full, t_full, s_full;
	logic signed [SUM_W-1:0]    y_sat, s_sat, base;
	logic [ENERGY_W:0]          e_sum;
	logic                       idx_last, band_last, close_blk;
	logic [BANDS_W-1:0]         bands_cl;
	logic [BAND_W-1:0]          rom_row;

	logic [SAMPLE_W-1:0] in_rdata;
	logic [SUM_W-1:0]    sum_rdata;
	logic                in_we, in_re, sum_we, sum_re;
	logic [ADDR_W-1:0]   in_waddr;
	logic signed [SUM_W-1:0] sum_wdata;

	logic                div_start, div_done, sq_start, sq_done;
	logic [ENERGY_W-1:0] div_num, div_quot;
	logic [ROOT_W-1:0]   div_den, sq_root;

	// stores
	mbc_ram #(.WIDTH(SAMPLE_W), .DEPTH(BLOCK_LEN)) u_input_store (
		.clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_ch.sample_in),
		.re(in_re), .raddr(idx_q), .rdata(in_rdata)
	);

	mbc_ram #(.WIDTH(SUM_W), .DEPTH(BLOCK_LEN)) u_sum_store (
		.clk(clk), .we(sum_we), .waddr(idx_q), .wdata(sum_wdata),
		.re(sum_re), .raddr(idx_q), .rdata(sum_rdata)
	);

	mbc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	mbc_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(div_quot),
		.done(sq_done), .root(sq_root)
	);

	// handshakes and store strobes
	assign in_ch.ready = state_q == ST_LOAD;
	assign in_we       = in_ch.valid && in_ch.ready;
	assign in_waddr    = cnt_q[ADDR_W-1:0];
	assign in_re       = state_q == ST_RD;
	assign sum_re      = (state_q == ST_RD) || (state_q == ST_OUT_RD);
	assign sum_we      = (state_q == ST_ACCUM) && pass_q;
	assign div_start   = (state_q == ST_DIVE_GO) || (state_q == ST_DIVG_GO);
	assign sq_start    = state_q == ST_SQ_GO;
	assign div_num     = (state_q == ST_DIVG_GO)
		? ENERGY_W'({thr_q, {FRAC_G{1'b0}}}) : energy_q;
	assign div_den     = (state_q == ST_DIVG_GO) ? rms_q : ROOT_W'(n_q);

	assign idx_last  = CNT_W'(idx_q) == n_q - CNT_W'(1);
	assign band_last = BANDS_W'(band_q) == bands_q - BANDS_W'(1);
	assign close_blk = in_ch.block_end || (cnt_q == CNT_W'(BLOCK_LEN - 1));
	assign rom_row   = BAND_W'(bands_q - BANDS_W'(1));

	// band count clamped to the supported range
	always_comb begin
		if (band_count_q == '0) bands_cl = BANDS_W'(1);
		else if (int'(band_count_q) > MAX_BANDS) bands_cl = BANDS_W'(MAX_BANDS);
		else bands_cl = BANDS_W'(band_count_q);
	end

	// shared multiplier operand select
	always_comb begin
		opa = '0;
		opb = '0;
		case (state_q)
			ST_MUL0: begin
				opa = MUL_W'(b0_q);
				opb = MUL_W'($signed(in_rdata)) - MUL_W'(xh2_q);
			end
			ST_MUL1: begin
				opa = MUL_W'(a1_q);
				opb = MUL_W'(yh1_q);
			end
			ST_MUL2: begin
				opa = MUL_W'(a2_q);
				opb = MUL_W'(yh2_q);
			end
			ST_MUL4: begin
				opa = MUL_W'(y_q);
				opb = pass_q ? $signed(MUL_W'({1'b0, gain_q})) : MUL_W'(y_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// filter output rounding and saturation
	always_comb begin
		y_full = (acc_q + (PROD_W'(1) <<< (FRAC_C - 1))) >>> FRAC_C;
		if (y_full > PROD_W'(SUM_MAX)) y_sat = SUM_MAX;
		else if (y_full < PROD_W'(SUM_MIN)) y_sat = SUM_MIN;
		else y_sat = y_full[SUM_W-1:0];
	end

	// gained band output added into the running sum
	always_comb begin
		base   = (band_q == '0) ? '0 : $signed(sum_rdata);
		t_full = (prod_q + (PROD_W'(1) <<< (FRAC_G - 1))) >>> FRAC_G;
		s_full = PROD_W'(base) + t_full;
		if (s_full > PROD_W'(SUM_MAX)) s_sat = SUM_MAX;
		else if (s_full < PROD_W'(SUM_MIN)) s_sat = SUM_MIN;
		else s_sat = s_full[SUM_W-1:0];
		sum_wdata = s_sat;
		e_sum = {1'b0, energy_q} + prod_q[ENERGY_W-1:0];
	end

	// result beat, sum saturated to the sample width
	always_comb begin
		out_ch.valid = state_q == ST_OUT_SHOW;
		out_ch.out_last = idx_last;
		if ($signed(sum_rdata) > SUM_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}})))
			out_ch.sample_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
		else if ($signed(sum_rdata) < SUM_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}})))
			out_ch.sample_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			out_ch.sample_out = sum_rdata[SAMPLE_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= BC_RESET;
			thr_cfg_q    <= THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAND_COUNT:      band_count_q <= cfg_data[BC_W-1:0];
				CFG_LEVEL_THRESHOLD: thr_cfg_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			n_q     <= CNT_W'(1);
			idx_q   <= '0;
			band_q  <= '0;
			pass_q  <= 1'b0;
			bands_q <= BANDS_W'(1);
			thr_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_we) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (close_blk) begin
							n_q     <= cnt_q + CNT_W'(1);
							bands_q <= bands_cl;
							thr_q   <= thr_cfg_q;
							band_q  <= '0;
							state_q <= ST_BAND_START;
						end
					end
				end
				ST_BAND_START: begin
					idx_q   <= '0;
					pass_q  <= 1'b0;
					state_q <= ST_RD;
				end
				ST_RD:    state_q <= ST_MUL0;
				ST_MUL0:  state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_YCALC;
				ST_YCALC: state_q <= ST_MUL4;
				ST_MUL4:  state_q <= ST_ACCUM;
				ST_ACCUM: begin
					if (!idx_last) begin
						idx_q   <= idx_q + ADDR_W'(1);
						state_q <= ST_RD;
					end else if (!pass_q) begin
						state_q <= ST_DIVE_GO;
					end else if (band_last) begin
						idx_q   <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						band_q  <= band_q + BAND_W'(1);
						state_q <= ST_BAND_START;
					end
				end
				ST_DIVE_GO:   state_q <= ST_DIVE_WAIT;
				ST_DIVE_WAIT: if (div_done) state_q <= ST_SQ_GO;
				ST_SQ_GO:     state_q <= ST_SQ_WAIT;
				ST_SQ_WAIT:   if (sq_done) state_q <= ST_GAIN;
				ST_GAIN: begin
					if (rms_q > ROOT_W'(thr_q)) state_q <= ST_DIVG_GO;
					else state_q <= ST_PASS_START;
				end
				ST_DIVG_GO:   state_q <= ST_DIVG_WAIT;
				ST_DIVG_WAIT: if (div_done) state_q <= ST_PASS_START;
				ST_PASS_START: begin
					idx_q   <= '0;
					pass_q  <= 1'b1;
					state_q <= ST_RD;
				end
				ST_OUT_RD: state_q <= ST_OUT_SHOW;
				ST_OUT_SHOW: begin
					if (out_ch.ready) begin
						if (idx_last) begin
							cnt_q   <= '0;
							idx_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + ADDR_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// biquad datapath, energy and gain
	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		case (state_q)
			ST_BAND_START: begin
				b0_q     <= $signed(COEF_ROM[rom_row][band_q][0]);
				a1_q     <= $signed(COEF_ROM[rom_row][band_q][1]);
				a2_q     <= $signed(COEF_ROM[rom_row][band_q][2]);
				xh1_q    <= '0;
				xh2_q    <= '0;
				yh1_q    <= '0;
				yh2_q    <= '0;
				energy_q <= '0;
			end
			ST_PASS_START: begin
				xh1_q <= '0;
				xh2_q <= '0;
				yh1_q <= '0;
				yh2_q <= '0;
			end
			ST_MUL1: acc_q <= prod_q;
			ST_MUL2: acc_q <= acc_q - prod_q;
			ST_MUL3: acc_q <= acc_q - prod_q;
			ST_YCALC: begin
				y_q   <= y_sat;
				xh2_q <= xh1_q;
				xh1_q <= $signed(in_rdata);
				yh2_q <= yh1_q;
				yh1_q <= y_sat;
			end
			ST_ACCUM: begin
				if (!pass_q) energy_q <= e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
			end
			ST_SQ_WAIT: if (sq_done) rms_q <= sq_root;
			ST_GAIN:    gain_q <= GAIN_ONE[GAIN_W-1:0];
			ST_DIVG_WAIT: if (div_done) gain_q <= div_quot[GAIN_W-1:0];
			default: ;
		endcase
	end

endmodule

/* bench/tb.sv */
// testbench of the multiband compressor: blocks of samples against a bit-exact predictor
// depends on mbc_pkg, mbc_if and the design top block_multiband_compressor
module tb import mbc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned LEVEL_CAP = 64'd281474976710655;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbc_in_if  in_ch ();
	mbc_out_if out_ch ();

	block_multiband_compressor u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// predictor state
	longint coef_tab[MAX_BANDS][MAX_BANDS][3];
	logic [BC_W-1:0] pred_bands;
	logic [THR_W-1:0] pred_thr;
	longint sample_mem[BLOCK_LEN];
	int sample_cnt;
	longint hist[4];
	result_t pending_out[$];
	int errors;
	bit calm;       // no idling on either side while set
	int cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat_to(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint near_div(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// sin(pi*n/d) in Q30 by a truncated series on the reduced angle
	function automatic longint sine_q30(longint n, longint d);
		longint r, acc;
		longint unsigned x, x2, term;
		bit neg;
		r = n % (2 * d);
		if (r < 0) r = r + 2 * d;
		neg = 1'b0;
		if (r >= d) begin
			neg = 1'b1;
			r = r - d;
		end
		if (2 * r > d) r = d - r;
		x = (PI_Q30 * longint'(r) + longint'(d / 2)) / longint'(d);
		x2 = (x * x) >> 30;
		term = x;
		acc = 0;
		for (int k = 0; k < 12; k++) begin
			if (k % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
			term = ((term * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
		end
		return neg ? -acc : acc;
	endfunction

	function automatic void build_coefs();
		longint alpha, a0, c;
		for (int b = 1; b <= MAX_BANDS; b++) begin
			alpha = near_div(sine_q30(1, b) * 500, 707);
			a0 = ONE_Q30 + alpha;
			for (int k = 0; k < b; k++) begin
				c = sine_q30(b - 2 * (2 * k + 1), 2 * b);
				coef_tab[b-1][k][0] = sat_to(near_div(alpha * 4194304, a0), COEF_W);
				coef_tab[b-1][k][1] = sat_to(near_div(-2 * c * 4194304, a0), COEF_W);
				coef_tab[b-1][k][2] = sat_to(near_div((ONE_Q30 - alpha) * 4194304, a0), COEF_W);
			end
		end
	endfunction

	// one biquad step on the shared history x1, x2, y1, y2
	function automatic longint biquad(int nb, int band, longint x0);
		longint acc, y;
		acc = coef_tab[nb-1][band][0] * (x0 - hist[1]) - coef_tab[nb-1][band][1] * hist[2]
			- coef_tab[nb-1][band][2] * hist[3];
		y = sat_to((acc + (64'sd1 <<< 21)) >>> 22, COEF_W);
		hist[1] = hist[0];
		hist[0] = x0;
		hist[3] = hist[2];
		hist[2] = y;
		return y;
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// whole-block compression, results go to the expected queue
	function automatic void compress_block();
		longint mix[BLOCK_LEN];
		longint y, gain;
		longint unsigned level, rms;
		int nb;
		result_t r;
		nb = (pred_bands == 0) ? 1 : int'(pred_bands);
		if (nb > MAX_BANDS) nb = MAX_BANDS;
		for (int i = 0; i < BLOCK_LEN; i++) mix[i] = 0;
		for (int b = 0; b < nb; b++) begin
			for (int h = 0; h < 4; h++) hist[h] = 0;
			level = 0;
			for (int i = 0; i < sample_cnt; i++) begin
				y = biquad(nb, b, sample_mem[i]);
				level = level + longint'(y * y);
				if (level > LEVEL_CAP) level = LEVEL_CAP;
			end
			rms = int_root(level / longint'(sample_cnt));
			gain = 32768;
			if (rms > pred_thr) gain = longint'((longint'(pred_thr) << 15) / rms);
			for (int h = 0; h < 4; h++) hist[h] = 0;
			for (int i = 0; i < sample_cnt; i++) begin
				y = biquad(nb, b, sample_mem[i]);
				mix[i] = sat_to(mix[i] + ((y * gain + 16384) >>> 15), SUM_W);
			end
		end
		for (int i = 0; i < sample_cnt; i++) begin
			r.sample = SAMPLE_W'(sat_to(mix[i], SAMPLE_W));
			r.last = (i + 1 == sample_cnt);
			pending_out.push_back(r);
		end
		sample_cnt = 0;
	endfunction

	function automatic void take_sample(logic signed [SAMPLE_W-1:0] s, logic e);
		sample_mem[sample_cnt] = s;
		sample_cnt++;
		if (e || sample_cnt >= BLOCK_LEN) compress_block();
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one input beat; called just after a rising edge
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic e);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= s;
		in_ch.block_end <= e;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		take_sample(s, e);
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_out.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_BAND_COUNT) pred_bands = val[BC_W-1:0];
		else if (idx == CFG_LEVEL_THRESHOLD) pred_thr = val[THR_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_block(int len, int shift);
		logic signed [SAMPLE_W-1:0] s;
		for (int i = 0; i < len; i++) begin
			s = $signed(SAMPLE_W'($urandom)) >>> shift;
			send_sample(s, i == len - 1);
		end
	endtask

	// extremes of the sample field, single-sample blocks, band count edge values
	task automatic test_directed();
		write_reg(CFG_BAND_COUNT, 2);
		send_sample(16'sh7fff, 1'b0);
		send_sample(-16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(-16'sh5556, 1'b1);
		wait_drained();
		// band count zero acts as one band: output all zero
		write_reg(CFG_BAND_COUNT, 0);
		send_block(4, 0);
		wait_drained();
		write_reg(CFG_BAND_COUNT, 1);
		send_sample(16'sh7fff, 1'b1);
		wait_drained();
		// above the band limit, threshold at both extremes
		write_reg(CFG_BAND_COUNT, 15);
		write_reg(CFG_LEVEL_THRESHOLD, 0);
		send_block(5, 0);
		wait_drained();
		write_reg(CFG_BAND_COUNT, 9);
		write_reg(CFG_LEVEL_THRESHOLD, 15'h7fff);
		send_block(4, 0);
		wait_drained();
		// out-of-range register indexes are ignored
		write_reg(cfg_reg_t'(2), 15'h0001);
		write_reg(cfg_reg_t'(15), 15'h7fff);
		send_block(3, 0);
		wait_drained();
	endtask

	// settings changed while samples are still being gathered
	task automatic test_midblock_config();
		write_reg(CFG_BAND_COUNT, 8);
		write_reg(CFG_LEVEL_THRESHOLD, 100);
		send_sample(16'sh4000, 1'b0);
		send_sample(-16'sh3000, 1'b0);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		write_reg(CFG_BAND_COUNT, 3);
		write_reg(CFG_LEVEL_THRESHOLD, 5000);
		send_sample(16'sh2000, 1'b1);
		wait_drained();
	endtask

	// 64 samples with no end mark close the block on their own
	task automatic test_full_block();
		logic signed [SAMPLE_W-1:0] s;
		write_reg(CFG_BAND_COUNT, 8);
		for (int i = 0; i < BLOCK_LEN; i++) begin
			s = SAMPLE_W'($urandom);
			send_sample(s, 1'b0);
		end
		wait_drained();
	endtask

	// mostly short blocks of random content, settings changed between blocks
	task automatic test_random();
		int sent, len;
		sent = 0;
		while (sent < 500) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_drained();
				write_reg(CFG_BAND_COUNT, $urandom_range(0, 15));
				case ($urandom_range(0, 3))
					0: write_reg(CFG_LEVEL_THRESHOLD, $urandom_range(0, 32767));
					1: write_reg(CFG_LEVEL_THRESHOLD, $urandom_range(0, 2000));
					2: write_reg(CFG_LEVEL_THRESHOLD, 15'h7fff);
					default: write_reg(CFG_LEVEL_THRESHOLD, 0);
				endcase
			end
			calm = ($urandom_range(0, 5) == 0);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 63) : $urandom_range(1, 12);
			send_block(len, $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0);
			sent += len;
		end
		calm = 1'b0;
		wait_drained();
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_out.size() == 0) begin
					$display("%0t unexpected result: got %0d last %0b", $realtime,
						out_ch.sample_out, out_ch.out_last);
					errors++;
				end else begin
					want = pending_out.pop_front();
					if (out_ch.sample_out !== want.sample) begin
						$display("%0t sample_out mismatch: expected %0d actual %0d", $realtime,
							want.sample, out_ch.sample_out);
						errors++;
					end
					if (out_ch.out_last !== want.last) begin
						$display("%0t out_last mismatch: expected %0b actual %0b", $realtime,
							want.last, out_ch.out_last);
						errors++;
					end
				end
			end
			out_ch.ready <= (pick_gap() == 0);
		end
	end

	// run-time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		sample_cnt = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		in_ch.block_end = 1'b0;
		out_ch.ready = 1'b0;
		build_coefs();
		pred_bands = BC_RESET;
		pred_thr = THR_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values used on the first block
		send_block(6, 0);
		wait_drained();
		test_directed();
		test_midblock_config();
		test_full_block();
		test_random();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* block_multiband_compressor.f */
design/mbc_pkg.sv
design/mbc_if.sv
design/mbc_ram.sv
design/mbc_div.sv
design/mbc_sqrt.sv
design/block_multiband_compressor.sv
bench/tb.sv
